// ===== design/sorted_table_bound_search_defines.svh =====
// Assertion helpers shared by the block's modules.
// Each one samples on the rising clock edge and stays quiet while reset is active.
`ifndef SORTED_TABLE_BOUND_SEARCH_DEFINES_SVH
`define SORTED_TABLE_BOUND_SEARCH_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define STBS_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define STBS_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== design/stbs_pkg.sv =====
`default_nettype none

package stbs_pkg;

    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int VALUE_WIDTH_DEF = 32;

    localparam int OP_W  = 2;
    localparam int IDX_W = 10;
    localparam int KEY_W = 32;
    localparam int POS_W = 11;

    localparam int IN_TDATA_W  = 48;
    localparam int OUT_TDATA_W = 16;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_LOWER = 2'd1,
        OP_UPPER = 2'd2,
        OP_FIND  = 2'd3
    } t_op;

    typedef struct packed {
        logic accept;    // input word taken this cycle
        logic issue;     // launch a table read at the next midpoint
        logic step;      // compare the returned entry and narrow the interval
        logic load_out;  // move the finished result into the output register
    } t_dp_cmd;

    typedef struct packed {
        logic direct;    // incoming word needs no search (write or empty table)
        logic done;      // search ends with this compare
    } t_dp_status;

endpackage

`default_nettype wire

// ===== design/stbs_ram.sv =====
`default_nettype none

module stbs_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire

// ===== design/stbs_datapath.sv =====
`default_nettype none
`include "sorted_table_bound_search_defines.svh"

module stbs_datapath #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    input  wire logic [stbs_pkg::POS_W-1:0]        i_cfg_data,
    input  wire logic [stbs_pkg::IN_TDATA_W-1:0]   i_in_data,
    input  wire stbs_pkg::t_dp_cmd                 i_cmd,
    output stbs_pkg::t_dp_status                   o_status,
    output logic      [stbs_pkg::OUT_TDATA_W-1:0]  o_out_data
);
    import stbs_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);

    // Input word fields.
    t_op                     in_op;
    logic [IDX_W-1:0]        in_idx;
    logic [KEY_W-1:0]        in_key;
    logic signed [VALUE_WIDTH-1:0] in_key_v;

    logic [POS_W-1:0] r_count;
    logic [POS_W-1:0] n_count;
    logic [POS_W-1:0] count_sat;

    t_op                           r_op;
    logic signed [VALUE_WIDTH-1:0] r_key;
    logic [POS_W-1:0]              r_lo, r_hi, r_mid, r_n;
    logic [POS_W-1:0]              n_lo, n_hi, mid_next;
    logic                          r_hit, r_empty;

    logic [VALUE_WIDTH-1:0]        rd_data;
    logic signed [VALUE_WIDTH-1:0] entry;
    logic                          go_left, hit_now;
    logic                          ram_we;
    logic [POS_W-1:0]              out_pos;
    logic [OUT_TDATA_W-1:0]        r_out_data;

    assign in_op    = t_op'(i_in_data[OP_W-1:0]);
    assign in_idx   = i_in_data[OP_W +: IDX_W];
    assign in_key   = i_in_data[OP_W+IDX_W +: KEY_W];
    assign in_key_v = VALUE_WIDTH'($signed(in_key));

    assign n_count   = i_cfg_valid ? i_cfg_data : r_count;
    assign count_sat = (32'(r_count) > TABLE_DEPTH) ? POS_W'(TABLE_DEPTH) : r_count;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else begin
            r_count <= n_count;
        end
    end

    // Writes land at acceptance; indexes beyond the table are dropped.
    assign ram_we = i_cmd.accept && (in_op == OP_WRITE) && (32'(in_idx) < TABLE_DEPTH);

    assign entry   = $signed(rd_data);
    assign hit_now = (r_op == OP_FIND) && (r_key == entry);
    assign go_left = (r_op == OP_LOWER) ? (r_key <= entry) : (r_key < entry);

    // The interval [lo, hi) holds the positions not yet ruled out.
    always_comb begin
        n_lo = r_lo;
        n_hi = r_hi;
        if (i_cmd.step) begin
            if (go_left) begin
                n_hi = r_mid;
            end else begin
                n_lo = r_mid + POS_W'(1);
            end
        end
    end

    assign mid_next = n_lo + ((n_hi - n_lo - POS_W'(1)) >> 1);

    assign o_status.direct = (in_op == OP_WRITE) || (r_count == '0);
    assign o_status.done   = hit_now || (n_hi == n_lo);

    stbs_ram #(
        .WIDTH (VALUE_WIDTH),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (AW'(in_idx)),
        .i_wdata (in_key_v),
        .i_raddr (AW'(mid_next)),
        .o_rdata (rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_op    <= in_op;
            r_key   <= in_key_v;
            r_n     <= count_sat;
            r_lo    <= '0;
            r_hi    <= (in_op == OP_WRITE) ? POS_W'(in_idx) : count_sat;
            r_hit   <= 1'b0;
            r_empty <= (in_op != OP_WRITE) && (r_count == '0);
        end else begin
            r_lo <= n_lo;
            r_hi <= n_hi;
            if (i_cmd.step && hit_now) begin
                r_hit <= 1'b1;
            end
        end
        if (i_cmd.issue) begin
            r_mid <= mid_next;
        end
    end

    assign out_pos = (r_op == OP_FIND) ? (r_hit ? r_mid : r_n) : r_hi;

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_out) begin
            r_out_data <= {(OUT_TDATA_W - POS_W - 2)'(0), r_empty, r_hit, out_pos};
        end
    end

    assign o_out_data = r_out_data;

    `STBS_ASSERT_SAME(a_interval_open, i_cmd.step, r_lo < r_hi,
        "compare issued on an empty search interval")
    `STBS_ASSERT_SAME(a_interval_bound, i_cmd.step, r_hi <= r_n,
        "search interval runs past the entry count")
    `STBS_ASSERT_NEXT(a_hit_only_find, i_cmd.step && hit_now, r_hit && r_op == OP_FIND,
        "hit recorded outside an exact find")

endmodule

`default_nettype wire

// ===== design/stbs_ctrl.sv =====
`default_nettype none
`include "sorted_table_bound_search_defines.svh"

module stbs_ctrl (
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    input  wire stbs_pkg::t_dp_status i_status,
    output stbs_pkg::t_dp_cmd         o_cmd
);
    import stbs_pkg::*;

    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_ADDR = 4'b0010,
        S_CMP  = 4'b0100,
        S_PUT  = 4'b1000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    logic   accept, load_out;

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign load_out   = (r_state == S_PUT) && (!r_out_valid || i_out_ready);

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (accept) begin
                    n_state = i_status.direct ? S_PUT : S_ADDR;
                end
            end
            S_ADDR: begin
                n_state = S_CMP;
            end
            S_CMP: begin
                if (i_status.done) begin
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                if (load_out) begin
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign n_out_valid = load_out || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_cmd.accept   = accept;
    assign o_cmd.issue    = (r_state == S_ADDR) || ((r_state == S_CMP) && !i_status.done);
    assign o_cmd.step     = (r_state == S_CMP);
    assign o_cmd.load_out = load_out;
    assign o_out_valid    = r_out_valid;

    `STBS_ASSERT_NEXT(a_search_reads, r_state == S_ADDR, r_state == S_CMP,
        "table read launched without a compare following")
    `STBS_ASSERT_SAME(a_result_from_put, $rose(r_out_valid), $past(r_state == S_PUT),
        "result word raised outside the result state")
    `STBS_ASSERT_NEXT(a_direct_word, accept && i_status.direct, r_state == S_PUT,
        "write or empty query did not go straight to the result")

endmodule

`default_nettype wire

// ===== design/sorted_table_bound_search.sv =====
// Binary search over a sorted table of signed values held in a block RAM. A write
// word stores key_value at entry_index and answers with that index; lower bound, upper
// bound and exact find search the first entry_count entries (saturated at the table
// depth; the user must set entry_count on the config port only while the block is idle,
// and the block itself does not enforce this). One word is handled at a time: a write
// or a query on an empty table goes straight to the result state, and any other query
// passes an address state and then one RAM read and compare per probe. A finished
// result sits in an output register, so the next word is taken while it waits. Entries
// that are searched must have been written first.
`default_nettype none

module sorted_table_bound_search #(
    parameter int TABLE_DEPTH = stbs_pkg::TABLE_DEPTH_DEF,
    parameter int VALUE_WIDTH = stbs_pkg::VALUE_WIDTH_DEF
) (
    input  wire logic                              i_clk,
    input  wire logic                              i_rst_n,
    input  wire logic                              i_cfg_valid,
    output logic                                   o_cfg_ready,
    input  wire logic [stbs_pkg::POS_W-1:0]        i_cfg_data,    // entry_count
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // operation[1:0], entry_index[11:2], key_value[43:12], zero fill
    input  wire logic [stbs_pkg::IN_TDATA_W-1:0]   s_tdata,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready,
    // position[10:0], found[11], empty_range[12], zero fill
    output logic      [stbs_pkg::OUT_TDATA_W-1:0]  m_tdata
);
    import stbs_pkg::*;

    t_dp_cmd    cmd;
    t_dp_status status;

    assign o_cfg_ready = 1'b1;

    stbs_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_tvalid),
        .o_in_ready  (s_tready),
        .o_out_valid (m_tvalid),
        .i_out_ready (m_tready),
        .i_status    (status),
        .o_cmd       (cmd)
    );

    stbs_datapath #(
        .TABLE_DEPTH (TABLE_DEPTH),
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_data  (i_cfg_data),
        .i_in_data   (s_tdata),
        .i_cmd       (cmd),
        .o_status    (status),
        .o_out_data  (m_tdata)
    );

endmodule

`default_nettype wire
